@@ hdl/brd_pkg.sv @@
// shared types and constants for the board reply deframer
`default_nettype none

package brd_pkg;

  localparam logic [7:0] START_BYTE = 8'h7F;
  localparam logic [7:0] DIGIT_LO = 8'h30;
  localparam logic [7:0] DIGIT_HI = 8'h39;
  localparam logic [11:0] DECODE_OFFSET = 12'd1000;
  localparam logic [3:0] TARGET_RESET = 4'd1;

  typedef enum logic [1:0] {
    MSG_JUNK        = 2'd0,
    MSG_RESULT      = 2'd1,
    MSG_REPORT      = 2'd2,
    MSG_NO_RESPONSE = 2'd3
  } msg_type_e;

  // position inside a frame, frame kind folded in
  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_RES_ID     = 3'd1,
    ST_RES_CODE   = 3'd2,
    ST_REP_ACC_HI = 3'd3,
    ST_REP_ACC_LO = 3'd4,
    ST_REP_DAT_HI = 3'd5,
    ST_REP_DAT_LO = 3'd6,
    ST_REP_CHECK  = 3'd7
  } frame_state_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timeout;
  } in_item_t;

  typedef struct packed {
    msg_type_e          msg_type;
    logic [3:0]         source_unit;
    logic [7:0]         result_code;
    logic signed [11:0] acc_value;
    logic signed [11:0] dat_value;
    logic               programmed;
    logic               from_target;
  } out_item_t;

endpackage

`default_nettype wire

@@ hdl/board_reply_deframer_top.sv @@
// board reply deframer: byte-wise reply frame recognizer with registered in and out
//
// usage
//   input channel (in_valid_i / in_stall_o / in_data_i) carries one received
//   serial byte or a timeout mark per transaction
//   output channel (out_valid_o / out_stall_i / out_data_o) carries one decoded
//   reply per transaction: junk, result frame, report frame or no response
//   config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes target_unit;
//   ready is always high, write only while the block is idle
// throughput
//   an accepted transaction waits in the input register, is decoded from there
//   and its result is offered from the result register; one transaction per
//   cycle sustained while the receiver does not stall, set by the single input
//   register and the single result register; bytes inside a frame give no result
// reset
//   frame tracking returns to waiting for a leading byte, target_unit is 1,
//   both channels empty
// stall behavior
//   while the result waits under out_stall_i the input register still takes a
//   byte; a byte whose turn comes while the result register is full and stalled
//   waits there and in_stall_o rises until the receiver takes the result
`default_nettype none

module board_reply_deframer_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire brd_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output brd_pkg::out_item_t     out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [3:0]        cfg_data_i
);

  // configuration register
  logic [3:0] target_q;

  // input register
  logic              in_valid_q;
  brd_pkg::in_item_t in_data_q;

  // frame tracking state
  brd_pkg::frame_state_e state_q, state_d;
  logic [7:0]  id_q, id_d;
  logic [10:0] acc_q, acc_d;
  logic [10:0] dat_q, dat_d;
  logic [7:0]  sum_q, sum_d;

  // result register
  logic               out_valid_q;
  brd_pkg::out_item_t out_data_q;

  // decode step outputs
  logic               advance;
  logic               step;
  logic               res_valid;
  brd_pkg::out_item_t res;
  logic [7:0]         b;
  logic               id_is_digit;
  logic               b_is_digit;
  logic [3:0]         id_unit;

  // result register free or being emptied this cycle
  assign advance     = !out_valid_q || !out_stall_i;
  assign step        = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign b           = in_data_q.rx_byte;
  assign b_is_digit  = (b >= brd_pkg::DIGIT_LO) && (b <= brd_pkg::DIGIT_HI);
  assign id_is_digit = (id_q >= brd_pkg::DIGIT_LO) && (id_q <= brd_pkg::DIGIT_HI);
  assign id_unit     = 4'(id_q - brd_pkg::DIGIT_LO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= brd_pkg::TARGET_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_data_i;
    end
  end

  // input register takes a transaction whenever it is not held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brd_pkg::ST_IDLE;
      id_q    <= '0;
      acc_q   <= '0;
      dat_q   <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      id_q    <= id_d;
      acc_q   <= acc_d;
      dat_q   <= dat_d;
      sum_q   <= sum_d;
    end
  end

  // next state and result for one byte
  always_comb begin
    state_d   = state_q;
    id_d      = id_q;
    acc_d     = acc_q;
    dat_d     = dat_q;
    sum_d     = sum_q;
    res_valid = 1'b0;
    res       = '0;
    if (step) begin
      if (in_data_q.timeout) begin
        // drop any partial frame
        state_d      = brd_pkg::ST_IDLE;
        id_d         = '0;
        acc_d        = '0;
        dat_d        = '0;
        sum_d        = '0;
        res_valid    = 1'b1;
        res.msg_type = brd_pkg::MSG_NO_RESPONSE;
      end else begin
        unique case (state_q)
          brd_pkg::ST_IDLE: begin
            if (b == brd_pkg::START_BYTE) begin
              state_d = brd_pkg::ST_RES_ID;
            end else if (b_is_digit) begin
              state_d = brd_pkg::ST_REP_ACC_HI;
              id_d    = b;
              acc_d   = '0;
              dat_d   = '0;
              sum_d   = '0;
            end else begin
              res_valid    = 1'b1;
              res.msg_type = brd_pkg::MSG_JUNK;
            end
          end
          brd_pkg::ST_RES_ID: begin
            id_d    = b;
            state_d = brd_pkg::ST_RES_CODE;
          end
          brd_pkg::ST_RES_CODE: begin
            state_d   = brd_pkg::ST_IDLE;
            id_d      = '0;
            acc_d     = '0;
            dat_d     = '0;
            sum_d     = '0;
            res_valid = 1'b1;
            if (id_is_digit) begin
              res.msg_type    = brd_pkg::MSG_RESULT;
              res.source_unit = id_unit;
              res.result_code = b;
              res.from_target = (id_unit == target_q);
            end else begin
              res.msg_type = brd_pkg::MSG_JUNK;
            end
          end
          brd_pkg::ST_REP_ACC_HI: begin
            acc_d   = {b[3:0], 7'b0};
            sum_d   = sum_q - b;
            state_d = brd_pkg::ST_REP_ACC_LO;
          end
          brd_pkg::ST_REP_ACC_LO: begin
            acc_d   = {acc_q[10:7], b[6:0]};
            sum_d   = sum_q - b;
            state_d = brd_pkg::ST_REP_DAT_HI;
          end
          brd_pkg::ST_REP_DAT_HI: begin
            dat_d   = {b[3:0], 7'b0};
            sum_d   = sum_q - b;
            state_d = brd_pkg::ST_REP_DAT_LO;
          end
          brd_pkg::ST_REP_DAT_LO: begin
            dat_d   = {dat_q[10:7], b[6:0]};
            sum_d   = sum_q - b;
            state_d = brd_pkg::ST_REP_CHECK;
          end
          brd_pkg::ST_REP_CHECK: begin
            state_d   = brd_pkg::ST_IDLE;
            id_d      = '0;
            acc_d     = '0;
            dat_d     = '0;
            sum_d     = '0;
            res_valid = 1'b1;
            // check byte low six bits against negated sum over four
            if (b[5:0] == sum_q[7:2]) begin
              res.msg_type    = brd_pkg::MSG_REPORT;
              res.source_unit = id_unit;
              res.acc_value   = $signed({1'b0, acc_q} - brd_pkg::DECODE_OFFSET);
              res.dat_value   = $signed({1'b0, dat_q} - brd_pkg::DECODE_OFFSET);
              res.programmed  = b[6];
              res.from_target = (id_unit == target_q);
            end else begin
              res.msg_type = brd_pkg::MSG_JUNK;
            end
          end
          default: begin
            state_d = brd_pkg::ST_IDLE;
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_data_q <= res;
    end
  end

endmodule

`default_nettype wire

@@ hdl/brd_checker.sv @@
// port-level assertions for the board reply deframer, bound to the top level
`default_nettype none

module brd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire brd_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire brd_pkg::out_item_t out_data_o,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o
);

  // stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");

  // input backpressure only comes from a stalled receiver
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i && out_valid_o)
    else $error("input stalled without output stall");

  // a timeout leaves the result register as no response when the receiver is free
  a_timeout_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.timeout) ##1 !out_stall_i
    |=> out_valid_o && out_data_o.msg_type == brd_pkg::MSG_NO_RESPONSE)
    else $error("timeout did not give no response");

  // target match only for decoded frames
  a_target_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.from_target
    |-> out_data_o.msg_type == brd_pkg::MSG_RESULT ||
        out_data_o.msg_type == brd_pkg::MSG_REPORT)
    else $error("target flag on junk or no response");

  // configuration writes never wait
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write held off");

endmodule

bind board_reply_deframer_top brd_checker u_brd_checker (.*);

`default_nettype wire

@@ dv/board_reply_deframer_checker.sv @@
// reply checker for the board reply deframer: predicts replies from accepted bytes and compares
`timescale 1ns / 1ps

module board_reply_deframer_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  brd_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  brd_pkg::out_item_t out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [3:0]         cfg_data_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  localparam int REPORT_LIMIT = 10;

  // predictor copy of the deframer state
  logic [3:0]            target_unit;
  brd_pkg::frame_state_e frame_pos;
  logic [7:0]            frame_id;
  logic [10:0]           acc_bits;
  logic [10:0]           dat_bits;
  logic [7:0]            neg_sum;

  brd_pkg::out_item_t expected_replies[$];
  brd_pkg::out_item_t predicted;
  brd_pkg::out_item_t oldest;

  function automatic void clear_frame();
    frame_pos = brd_pkg::ST_IDLE;
    frame_id  = 8'd0;
    acc_bits  = 11'd0;
    dat_bits  = 11'd0;
    neg_sum   = 8'd0;
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return (b >= brd_pkg::DIGIT_LO) && (b <= brd_pkg::DIGIT_HI);
  endfunction

  function automatic string show_reply(input brd_pkg::out_item_t r);
    return $sformatf("type=%0d unit=%0d code=%02h acc=%0d dat=%0d prog=%0b tgt=%0b",
                     r.msg_type, r.source_unit, r.result_code, $signed(r.acc_value),
                     $signed(r.dat_value), r.programmed, r.from_target);
  endfunction

  // advance the frame tracker by one accepted item, returns 1 when a reply is due
  function automatic bit predict_reply(input brd_pkg::in_item_t item,
                                       output brd_pkg::out_item_t reply);
    logic [7:0] b;
    logic [3:0] unit;
    logic       ok;
    b     = item.rx_byte;
    reply = '0;
    if (item.timeout) begin
      clear_frame();
      reply.msg_type = brd_pkg::MSG_NO_RESPONSE;
      return 1'b1;
    end
    unit = 4'(frame_id - brd_pkg::DIGIT_LO);
    // the four data bytes of a report feed the negated sum
    if (frame_pos >= brd_pkg::ST_REP_ACC_HI && frame_pos <= brd_pkg::ST_REP_DAT_LO)
      neg_sum = neg_sum - b;
    case (frame_pos)
      brd_pkg::ST_IDLE: begin
        if (b == brd_pkg::START_BYTE) begin
          frame_pos = brd_pkg::ST_RES_ID;
          return 1'b0;
        end
        if (is_digit(b)) begin
          clear_frame();
          frame_id  = b;
          frame_pos = brd_pkg::ST_REP_ACC_HI;
          return 1'b0;
        end
        reply.msg_type = brd_pkg::MSG_JUNK;
        return 1'b1;
      end
      brd_pkg::ST_RES_ID: begin
        frame_id  = b;
        frame_pos = brd_pkg::ST_RES_CODE;
      end
      brd_pkg::ST_RES_CODE: begin
        ok = is_digit(frame_id);
        clear_frame();
        if (ok) begin
          reply.msg_type    = brd_pkg::MSG_RESULT;
          reply.source_unit = unit;
          reply.result_code = b;
          reply.from_target = (unit == target_unit);
        end else begin
          reply.msg_type = brd_pkg::MSG_JUNK;
        end
        return 1'b1;
      end
      brd_pkg::ST_REP_ACC_HI: begin
        acc_bits  = {b[3:0], 7'd0};
        frame_pos = brd_pkg::ST_REP_ACC_LO;
      end
      brd_pkg::ST_REP_ACC_LO: begin
        acc_bits[6:0] = b[6:0];
        frame_pos     = brd_pkg::ST_REP_DAT_HI;
      end
      brd_pkg::ST_REP_DAT_HI: begin
        dat_bits  = {b[3:0], 7'd0};
        frame_pos = brd_pkg::ST_REP_DAT_LO;
      end
      brd_pkg::ST_REP_DAT_LO: begin
        dat_bits[6:0] = b[6:0];
        frame_pos     = brd_pkg::ST_REP_CHECK;
      end
      default: begin
        ok = (b[5:0] == neg_sum[7:2]);
        if (ok) begin
          reply.msg_type    = brd_pkg::MSG_REPORT;
          reply.source_unit = unit;
          reply.acc_value   = {1'b0, acc_bits} - brd_pkg::DECODE_OFFSET;
          reply.dat_value   = {1'b0, dat_bits} - brd_pkg::DECODE_OFFSET;
          reply.programmed  = b[6];
          reply.from_target = (unit == target_unit);
        end else begin
          reply.msg_type = brd_pkg::MSG_JUNK;
        end
        clear_frame();
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_unit = brd_pkg::TARGET_RESET;
      clear_frame();
      expected_replies.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) target_unit = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_replies.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= REPORT_LIMIT)
            $display("%0t: reply with none expected: %s", $time, show_reply(out_data_i));
        end else begin
          oldest = expected_replies.pop_front();
          if (out_data_i.msg_type !== oldest.msg_type ||
              out_data_i.source_unit !== oldest.source_unit ||
              out_data_i.result_code !== oldest.result_code ||
              out_data_i.acc_value !== oldest.acc_value ||
              out_data_i.dat_value !== oldest.dat_value ||
              out_data_i.programmed !== oldest.programmed ||
              out_data_i.from_target !== oldest.from_target) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= REPORT_LIMIT) begin
              $display("%0t: reply mismatch", $time);
              $display("  expected %s", show_reply(oldest));
              $display("  actual   %s", show_reply(out_data_i));
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (predict_reply(in_data_i, predicted)) expected_replies.push_back(predicted);
      end
      pending_o = expected_replies.size();
    end
  end

endmodule

@@ dv/tb_board_reply_deframer_top.sv @@
// testbench top for the board reply deframer: stimulus, idling, configuration and verdict
`timescale 1ns / 1ps

module tb_board_reply_deframer_top;

  localparam int PHASE_ITEMS = 150;
  localparam int NUM_PHASES  = 6;
  // long receiver hold-off, long enough to back the block up into its input
  localparam int HOLD_CYCLES = 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  brd_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  brd_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [3:0]         cfg_data = 4'd0;

  int pending;
  int fail_count;

  // sender and receiver idling profile, changed per phase
  int gap_max = 0;
  int burst_max = 1;
  int burst_left = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int run_left = 0;
  bit run_stall = 1'b0;
  int items_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  board_reply_deframer_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  board_reply_deframer_checker reply_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  // receiver: stall runs of random length, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_stall = ($urandom_range(99) < stall_pct);
        run_left  = $urandom_range(4, 1);
      end
      run_left--;
      out_stall <= run_stall;
    end
  end

  // one transaction on the input channel; valid stays high inside a burst
  task automatic offer_rx(input logic [7:0] b, input logic to);
    brd_pkg::in_item_t item;
    int                gap;
    item.rx_byte = b;
    item.timeout = to;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(burst_max, 1);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    // stall is sampled as it stood before the edge
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // report frame: id, four data bytes, check byte; keep < 6 cuts it short with a timeout
  task automatic send_report_frame(input logic [7:0] id, input logic [7:0] d1,
                                   input logic [7:0] d2, input logic [7:0] d3,
                                   input logic [7:0] d4, input bit good, input bit prog,
                                   input int keep);
    logic [7:0]      sum;
    logic [7:0]      chk;
    logic [5:0][7:0] frame;
    sum    = 8'd0 - d1 - d2 - d3 - d4;
    chk    = {1'b0, prog, sum[7:2]};
    chk[7] = 1'($urandom_range(1));
    // a bad check flips one of the compared low bits
    if (!good) chk = chk ^ (8'd1 << $urandom_range(5));
    frame = {id, d1, d2, d3, d4, chk};
    for (int i = 0; i < keep; i++) offer_rx(frame[5 - i], 1'b0);
    if (keep < 6) offer_rx(8'($urandom_range(255)), 1'b1);
  endtask

  // result frame: start byte, id, result code
  task automatic send_result_frame(input logic [7:0] id, input logic [7:0] code,
                                   input int keep);
    logic [2:0][7:0] frame;
    frame = {brd_pkg::START_BYTE, id, code};
    for (int i = 0; i < keep; i++) offer_rx(frame[2 - i], 1'b0);
    if (keep < 3) offer_rx(8'($urandom_range(255)), 1'b1);
  endtask

  // mostly well-formed frames with random content, some broken frames and noise
  task automatic send_random_frame();
    int         pick;
    logic [7:0] id;
    pick = $urandom_range(99);
    id   = 8'(brd_pkg::DIGIT_LO + $urandom_range(9));
    if (pick < 40) begin
      send_report_frame(id, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1,
                        1'($urandom_range(1)), 6);
    end else if (pick < 65) begin
      // now and then a result frame with an arbitrary id byte
      if ($urandom_range(9) == 0) id = 8'($urandom_range(255));
      send_result_frame(id, 8'($urandom_range(255)), 3);
    end else if (pick < 73) begin
      send_report_frame(id, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0,
                        1'($urandom_range(1)), 6);
    end else if (pick < 83) begin
      // frame abandoned by a timeout part way through
      if ($urandom_range(1))
        send_report_frame(id, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1,
                          1'($urandom_range(1)), $urandom_range(5, 1));
      else
        send_result_frame(id, 8'($urandom_range(255)), $urandom_range(2, 1));
    end else if (pick < 93) begin
      offer_rx(8'($urandom_range(255)), 1'b0);
    end else begin
      offer_rx(8'($urandom_range(255)), 1'b1);
    end
  endtask

  // hold the sender until every expected reply is out, then let the pipe settle
  task automatic wait_replies_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_target_unit(input logic [3:0] unit);
    cfg_valid <= 1'b1;
    cfg_data  <= unit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int phase_end;
    bit paused;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, target unit still at its reset value
    // timeout with a byte that would otherwise start a frame
    offer_rx(brd_pkg::START_BYTE, 1'b1);
    // unknown leading bytes, one just above the digits
    offer_rx(8'h00, 1'b0);
    offer_rx(8'hFF, 1'b0);
    offer_rx(8'h3A, 1'b0);
    // result frame from the target unit
    send_result_frame(brd_pkg::DIGIT_LO + 8'd1, 8'h01, 3);
    // result frame with a non-digit id gives junk
    send_result_frame(8'h2F, 8'hFF, 3);
    // report at the decode extremes: acc at its top, dat at its bottom
    send_report_frame(brd_pkg::DIGIT_HI, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1, 6);
    // report with a bad check byte
    send_report_frame(brd_pkg::DIGIT_LO, 8'h35, 8'h5A, 8'h0F, 8'h7F, 1'b0, 1'b0, 6);
    // report dropped by a timeout after its first data byte
    send_report_frame(brd_pkg::DIGIT_LO + 8'd5, 8'h10, 8'h20, 8'h30, 8'h40, 1'b1, 1'b0, 2);
    wait_replies_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // target unit and idling profile per phase; 15 and 10 never match a source
      case (p)
        0: begin write_target_unit(4'd0);  gap_max = 0;  burst_max = 1;  stall_pct = 0;  end
        1: begin write_target_unit(4'd9);  gap_max = 6;  burst_max = 8;  stall_pct = 30; end
        2: begin write_target_unit(4'd15); gap_max = 0;  burst_max = 1;  stall_pct = 10; end
        3: begin write_target_unit(4'd10); gap_max = 3;  burst_max = 3;  stall_pct = 60; end
        4: begin
          write_target_unit(4'($urandom_range(9)));
          gap_max = 10; burst_max = 1; stall_pct = 20;
        end
        default: begin write_target_unit(4'd1); gap_max = 2; burst_max = 20; stall_pct = 0; end
      endcase
      burst_left = 0;
      // long receiver hold-off while the sender keeps pushing back to back
      if (p == 2) hold_requests++;
      phase_end = items_sent + PHASE_ITEMS;
      paused    = 1'b0;
      while (items_sent < phase_end) begin
        send_random_frame();
        // sender pause half way until all replies are out
        if (p == 4 && !paused && items_sent > phase_end - PHASE_ITEMS / 2) begin
          paused = 1'b1;
          wait_replies_drained();
          burst_left = 0;
        end
      end
      // a timeout closes any frame left open before the next register write
      offer_rx(8'($urandom_range(255)), 1'b1);
      wait_replies_drained();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin : watchdog
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
